// File: hw/rtl/matrix_multiply_unit_macros.svh
// Assertion macros shared by the matrix multiply unit RTL.
`ifndef MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define MMU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define MMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `MMU_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)
`else
`define MMU_ASSERT(lbl, clk, rst_n, prop, msg)
`define MMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/mmu_pkg.sv
// Shared constants, types and helpers of the matrix multiply unit.
`timescale 1ns / 1ps
package mmu_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 4;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH) + 1;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
  localparam int FRAC_W  = 16;
  localparam int SH_W    = ACC_W - FRAC_W;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH) + 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_idx_e;

  // One queued job: an optional store write and an optional product run
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              done;
    logic [DIM_W-1:0]  ra;
    logic [DIM_W-1:0]  ni;
    logic [DIM_W-1:0]  cb;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_status_t;

  // Map a register value to the dimension it stands for
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mmu_front.sv
// Front end: configuration registers, load counters and job classification.
`timescale 1ns / 1ps
module mmu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mmu_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic signed [31:0]          value_i,
  input  mmu_pkg::q_status_t          q_status_i,
  output logic                        push_o,
  output mmu_pkg::job_t               job_o
);

  logic [mmu_pkg::DIM_W-1:0] rows_a_q, inner_q, cols_b_q;
  logic [mmu_pkg::CNT_W-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [mmu_pkg::DIM_W-1:0] ra, ni, cb;
  logic [mmu_pkg::CNT_W-1:0] a_size, b_size, a_inc, b_inc;
  logic                      accept, a_wr, b_wr, done;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status_i.full;
  assign accept      = in_valid_i && !q_status_i.full;

  // Effective dimensions and matrix sizes
  assign ra     = mmu_pkg::eff_dim(rows_a_q);
  assign ni     = mmu_pkg::eff_dim(inner_q);
  assign cb     = mmu_pkg::eff_dim(cols_b_q);
  assign a_size = mmu_pkg::CNT_W'(ra) * mmu_pkg::CNT_W'(ni);
  assign b_size = mmu_pkg::CNT_W'(ni) * mmu_pkg::CNT_W'(cb);

  // Classify the item: store it or drop it, and test for completion
  assign a_wr  = !kind_i && (a_cnt_q < a_size);
  assign b_wr  = kind_i && (b_cnt_q < b_size);
  assign a_inc = a_cnt_q + mmu_pkg::CNT_W'(a_wr);
  assign b_inc = b_cnt_q + mmu_pkg::CNT_W'(b_wr);
  assign done  = (a_inc >= a_size) && (b_inc >= b_size);

  always_comb begin
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    if (accept) begin
      a_cnt_d = done ? '0 : a_inc;
      b_cnt_d = done ? '0 : b_inc;
    end
  end

  // Build the queue entry
  assign push_o      = accept && (a_wr || b_wr || done);
  assign job_o.wr_a  = a_wr;
  assign job_o.wr_b  = b_wr;
  assign job_o.addr  = kind_i ? b_cnt_q[mmu_pkg::ADDR_W-1:0] : a_cnt_q[mmu_pkg::ADDR_W-1:0];
  assign job_o.value = value_i;
  assign job_o.done  = done;
  assign job_o.ra    = ra;
  assign job_o.ni    = ni;
  assign job_o.cb    = cb;

  // Hold configuration and load counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mmu_pkg::DIM_W'(mmu_pkg::MAX_DIM);
      inner_q  <= mmu_pkg::DIM_W'(mmu_pkg::MAX_DIM);
      cols_b_q <= mmu_pkg::DIM_W'(mmu_pkg::MAX_DIM);
      a_cnt_q  <= '0;
      b_cnt_q  <= '0;
    end else begin
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mmu_pkg::CFG_ROWS_A: rows_a_q <= cfg_data_i;
          mmu_pkg::CFG_INNER:  inner_q  <= cfg_data_i;
          mmu_pkg::CFG_COLS_B: cols_b_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/mmu_fifo.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module mmu_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mmu_pkg::job_t      job_i,
  input  logic               pop_i,
  output mmu_pkg::job_t      head_o,
  output mmu_pkg::q_status_t status_o
);

  mmu_pkg::job_t              mem_q [mmu_pkg::QDEPTH];
  logic [mmu_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mmu_pkg::QCNT_W-1:0] count_q, count_d;
  logic                       do_push, do_pop;

  assign status_o.full  = (count_q == mmu_pkg::QCNT_W'(mmu_pkg::QDEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + mmu_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - mmu_pkg::QCNT_W'(1);
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + mmu_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + mmu_pkg::QPTR_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: hw/rtl/mmu_back.sv
// Back end: element stores, multiply-accumulate sequencer and result register.
`timescale 1ns / 1ps
module mmu_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmu_pkg::job_t               job_i,
  input  mmu_pkg::q_status_t          q_status_i,
  output mmu_pkg::back_status_t       status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          value_res_o,
  output logic [2:0]                  row_o,
  output logic [2:0]                  col_o,
  output logic                        last_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e                     state_q, state_d;
  logic [mmu_pkg::IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [mmu_pkg::DIM_W-1:0]  ra_q, ra_d, ni_q, ni_d, cb_q, cb_d;
  logic [mmu_pkg::ADDR_W-1:0] row_base_q, row_base_d, a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic [mmu_pkg::IDX_W-1:0]  last_i, last_j, last_k;
  logic                       advance, issue, pop;

  logic [mmu_pkg::DATA_W-1:0] a_rd, b_rd;

  // Pipeline tags: read stage and product stage
  logic                       v1_q, v2_q;
  logic                       first1_q, first2_q, lastk1_q, lastk2_q, laste1_q, laste2_q;
  logic [mmu_pkg::IDX_W-1:0]  row1_q, row2_q, col1_q, col2_q;
  logic signed [mmu_pkg::PROD_W-1:0] prod_q;
  logic signed [mmu_pkg::ACC_W-1:0]  acc_q, acc_sum;
  logic [mmu_pkg::SH_W-1:0]   sh;
  logic [mmu_pkg::DATA_W-1:0] sat_val;
  logic                       fits;

  logic                       out_valid_q;
  logic [mmu_pkg::DATA_W-1:0] out_value_q;
  logic [mmu_pkg::IDX_W-1:0]  out_row_q, out_col_q;
  logic                       out_last_q;

  // The whole pipeline moves only when the result register can take a value
  assign advance = !out_valid_q || !out_stall_i;
  assign issue   = (state_q == S_RUN) && advance;
  assign pop     = (state_q == S_IDLE) && !q_status_i.empty;

  assign status_o.pop  = pop;
  assign status_o.busy = (state_q == S_RUN);

  assign last_i = mmu_pkg::IDX_W'(ra_q - mmu_pkg::DIM_W'(1));
  assign last_j = mmu_pkg::IDX_W'(cb_q - mmu_pkg::DIM_W'(1));
  assign last_k = mmu_pkg::IDX_W'(ni_q - mmu_pkg::DIM_W'(1));

  mmu_ram #(
    .WIDTH(mmu_pkg::DATA_W),
    .DEPTH(mmu_pkg::DEPTH)
  ) u_a_store (
    .clk_i  (clk_i),
    .we_i   (pop && job_i.wr_a),
    .waddr_i(job_i.addr),
    .wdata_i(job_i.value),
    .re_i   (issue),
    .raddr_i(a_addr_q),
    .rdata_o(a_rd)
  );

  mmu_ram #(
    .WIDTH(mmu_pkg::DATA_W),
    .DEPTH(mmu_pkg::DEPTH)
  ) u_b_store (
    .clk_i  (clk_i),
    .we_i   (pop && job_i.wr_b),
    .waddr_i(job_i.addr),
    .wdata_i(job_i.value),
    .re_i   (issue),
    .raddr_i(b_addr_q),
    .rdata_o(b_rd)
  );

  // Sequence the loops: k innermost, then column, then row
  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    ra_d       = ra_q;
    ni_d       = ni_q;
    cb_d       = cb_q;
    row_base_d = row_base_q;
    a_addr_d   = a_addr_q;
    b_addr_d   = b_addr_q;
    case (state_q)
      S_IDLE: begin
        if (pop && job_i.done) begin
          state_d    = S_RUN;
          ra_d       = job_i.ra;
          ni_d       = job_i.ni;
          cb_d       = job_i.cb;
          i_d        = '0;
          j_d        = '0;
          k_d        = '0;
          row_base_d = '0;
          a_addr_d   = '0;
          b_addr_d   = '0;
        end
      end
      S_RUN: begin
        if (issue) begin
          if (k_q == last_k) begin
            k_d = '0;
            if (j_q == last_j) begin
              j_d = '0;
              if (i_q == last_i) begin
                state_d = S_IDLE;
              end else begin
                i_d        = i_q + mmu_pkg::IDX_W'(1);
                row_base_d = row_base_q + mmu_pkg::ADDR_W'(ni_q);
                a_addr_d   = row_base_q + mmu_pkg::ADDR_W'(ni_q);
                b_addr_d   = '0;
              end
            end else begin
              j_d      = j_q + mmu_pkg::IDX_W'(1);
              a_addr_d = row_base_q;
              b_addr_d = mmu_pkg::ADDR_W'(j_q) + mmu_pkg::ADDR_W'(1);
            end
          end else begin
            k_d      = k_q + mmu_pkg::IDX_W'(1);
            a_addr_d = a_addr_q + mmu_pkg::ADDR_W'(1);
            b_addr_d = b_addr_q + mmu_pkg::ADDR_W'(cb_q);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      ra_q       <= mmu_pkg::DIM_W'(1);
      ni_q       <= mmu_pkg::DIM_W'(1);
      cb_q       <= mmu_pkg::DIM_W'(1);
      row_base_q <= '0;
      a_addr_q   <= '0;
      b_addr_q   <= '0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      ra_q       <= ra_d;
      ni_q       <= ni_d;
      cb_q       <= cb_d;
      row_base_q <= row_base_d;
      a_addr_q   <= a_addr_d;
      b_addr_q   <= b_addr_d;
    end
  end

  // Accumulate, floor-shift and saturate
  assign acc_sum = (first2_q ? mmu_pkg::ACC_W'(0) : acc_q) + mmu_pkg::ACC_W'(prod_q);
  assign sh      = acc_sum[mmu_pkg::ACC_W-1:mmu_pkg::FRAC_W];
  assign fits    = (&sh[mmu_pkg::SH_W-1:mmu_pkg::DATA_W-1]) ||
                   !(|sh[mmu_pkg::SH_W-1:mmu_pkg::DATA_W-1]);
  assign sat_val = fits ? sh[mmu_pkg::DATA_W-1:0] :
                   (sh[mmu_pkg::SH_W-1] ? mmu_pkg::SAT_MIN : mmu_pkg::SAT_MAX);

  // Advance valid bits of the pipeline and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      out_valid_q <= v2_q && lastk2_q;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      first1_q <= (k_q == '0);
      lastk1_q <= (k_q == last_k);
      laste1_q <= (k_q == last_k) && (j_q == last_j) && (i_q == last_i);
      row1_q   <= i_q;
      col1_q   <= j_q;
      first2_q <= first1_q;
      lastk2_q <= lastk1_q;
      laste2_q <= laste1_q;
      row2_q   <= row1_q;
      col2_q   <= col1_q;
      prod_q   <= $signed(a_rd) * $signed(b_rd);
      if (v2_q) begin
        acc_q <= acc_sum;
      end
      out_value_q <= sat_val;
      out_row_q   <= row2_q;
      out_col_q   <= col2_q;
      out_last_q  <= laste2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign row_o       = out_row_q;
  assign col_o       = out_col_q;
  assign last_o      = out_last_q;

endmodule

// File: hw/rtl/matrix_multiply_unit.sv
// Top level of the Q16.16 matrix multiply unit.
//
//   channel  direction  handshake                  payload
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o    kind_i, value_i
//   out      out        out_valid_o / out_stall_i  value_res_o, row_o, col_o, last_o
//
// The front end takes one element per cycle, while the queue is not full, into a four-entry job queue.
// Each job writes at most one element store entry; a completing job then runs
// rows_a * cols_b * inner_size products on the single multiply-accumulate unit, through
// the product and result registers. Queue draining waits for the run.
// Reset clears counters, queue and pipeline; the element stores are not cleared.
// A stalled result freezes the multiply pipeline; a full queue stalls the input.
`timescale 1ns / 1ps
`include "matrix_multiply_unit_macros.svh"
module matrix_multiply_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_res_o,
  output logic [2:0]         row_o,
  output logic [2:0]         col_o,
  output logic               last_o
);

  mmu_pkg::job_t         push_job, head_job;
  logic                  push;
  mmu_pkg::q_status_t    fifo_status;
  mmu_pkg::back_status_t back_status;

  mmu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .q_status_i (fifo_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  mmu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (back_status.pop),
    .head_o  (head_job),
    .status_o(fifo_status)
  );

  mmu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .q_status_i (fifo_status),
    .status_o   (back_status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_res_o(value_res_o),
    .row_o      (row_o),
    .col_o      (col_o),
    .last_o     (last_o)
  );

  // Queue occupancy stays within its depth
  `MMU_ASSERT(a_q_bound, clk_i, rst_ni, fifo_status.count <= mmu_pkg::QDEPTH, "queue overflow")
  // Front end never pushes into a full queue
  `MMU_ASSERT_IMPL(a_push_full, clk_i, rst_ni, push, !fifo_status.full, "push while full")
  // Back end only pops an occupied queue while not running a product
  `MMU_ASSERT_IMPL(a_pop_ok, clk_i, rst_ni, back_status.pop, !fifo_status.empty && !back_status.busy, "bad pop")

endmodule
